FILE: rtl/txcc_pkg.sv
// Shared types and constants for the text console cursor engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package txcc_pkg;

    localparam int ROWS  = 25;
    localparam int COLS  = 80;
    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int POS_W = 11;
    localparam int OUT_W = 72;

    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_ESCAPE    = 8'h1B;
    localparam logic [7:0] CHAR_BRACKET   = 8'h5B;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_THREE     = 8'h33;
    localparam logic [7:0] CHAR_SEVEN     = 8'h37;
    localparam logic [7:0] CHAR_M         = 8'h6D;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;
    localparam logic [7:0] ATTR_DEFAULT   = 8'h0F;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_NEWLINE,
        OP_RETURN,
        OP_BACKSPACE
    } op_kind_t;

    typedef struct packed {
        op_kind_t   op;
        logic [7:0] ch;
        logic [7:0] attr;
    } cmd_t;

    function automatic logic [7:0] colour_attr(input logic [2:0] digit);
        logic [7:0] attr;
        case (digit)
            3'd0:    attr = 8'h00;
            3'd1:    attr = 8'h04;
            3'd2:    attr = 8'h02;
            3'd3:    attr = 8'h06;
            3'd4:    attr = 8'h01;
            3'd5:    attr = 8'h05;
            3'd6:    attr = 8'h03;
            default: attr = 8'h07;
        endcase
        return attr;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: 25 x 80 cell ring screen.
// Instantiates txcc_front, txcc_queue and txcc_back; uses txcc_pkg.
//
// Usage:
//   s_* carries one character byte per beat. Each accepted beat yields
//   exactly one m_* beat, in order: cell write (if any), row clear on
//   scroll (if any), top row and linear cursor position after the byte.
//   Escape sequences ESC [ 0 m and ESC [ 3 d m set the attribute; their
//   bytes and any byte that breaks a sequence give a beat with no write.
//   A byte accepted on s_* is written into the queue; when the back end pops
//   it, the result is registered in the result register and presented on
//   m_*. Throughput: one byte per cycle sustained while m_tready stays high.
//   When m_tready is low the result register holds, the two-entry queue
//   fills, and s_tready drops once it is full; nothing is lost.
//   Reset (rst_n low) puts the cursor at row 0 column 0, top row 0,
//   attribute 0x0F, the escape parser idle, and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine
    import txcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] write_enable, [5:1] write_row, [12:6] write_col, [28:13] cell_value,
    // [29] clear_enable, [34:30] clear_row_index, [50:35] fill_value,
    // [55:51] top_row, [66:56] cursor_position, [71:67] zero
    output logic [OUT_W-1:0] m_tdata
);

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    assign s_tready = push_ready;

    txcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_char    (s_tdata),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    txcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    txcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/txcc_front.sv
// Front end: accepts input bytes, runs the escape parser, owns the attribute.
// Classifies each byte into a command for the back end. Uses txcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module txcc_front
    import txcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic [7:0] in_char,
    input  wire logic push_ready,
    output logic      push_valid,
    output cmd_t      push_cmd
);

    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_OPEN,
        ESC_PARAM,
        ESC_RESET,
        ESC_FG,
        ESC_FG_END
    } esc_state_t;

    esc_state_t state_reg, state_next;
    logic [7:0] attr_reg, attr_next;
    logic [2:0] digit_reg, digit_next;
    op_kind_t   op;
    logic       accept;

    assign accept = in_valid && push_ready;

    always_comb
    begin
        state_next = ESC_IDLE;
        attr_next  = attr_reg;
        digit_next = digit_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ESC_OPEN:
            begin
                if (in_char == CHAR_BRACKET)
                    state_next = ESC_PARAM;
            end
            ESC_PARAM:
            begin
                if (in_char == CHAR_ZERO)
                    state_next = ESC_RESET;
                else if (in_char == CHAR_THREE)
                    state_next = ESC_FG;
            end
            ESC_RESET:
            begin
                if (in_char == CHAR_M)
                    attr_next = ATTR_DEFAULT;
            end
            ESC_FG:
            begin
                if (in_char >= CHAR_ZERO && in_char <= CHAR_SEVEN)
                begin
                    digit_next = in_char[2:0];
                    state_next = ESC_FG_END;
                end
            end
            ESC_FG_END:
            begin
                if (in_char == CHAR_M)
                    attr_next = colour_attr(digit_reg);
            end
            default:
            begin
                unique case (in_char)
                    CHAR_ESCAPE:    state_next = ESC_OPEN;
                    CHAR_NEWLINE:   op = OP_NEWLINE;
                    CHAR_RETURN:    op = OP_RETURN;
                    CHAR_BACKSPACE: op = OP_BACKSPACE;
                    default:        op = OP_WRITE;
                endcase
            end
        endcase
    end

    assign push_valid    = in_valid;
    assign push_cmd.op   = op;
    assign push_cmd.ch   = in_char;
    assign push_cmd.attr = attr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ESC_IDLE;
            attr_reg  <= ATTR_DEFAULT;
            digit_reg <= 3'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            attr_reg  <= attr_next;
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/txcc_queue.sv
// Two-entry command queue between the front and back ends.
// Uses cmd_t from txcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module txcc_queue
    import txcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  cmd_t      push_cmd,
    output logic      push_ready,
    output logic      pop_valid,
    output cmd_t      pop_cmd,
    input  wire logic pop_ready
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with misaligned pointers");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("full queue with misaligned pointers");

endmodule

`default_nettype wire

FILE: rtl/txcc_back.sv
// Back end: carries out commands on the cursor and ring offset and registers
// one result beat per command. Uses txcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module txcc_back
    import txcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pop_valid,
    input  cmd_t      pop_cmd,
    output logic      pop_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic [OUT_W-1:0] out_data
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] top_reg, top_next;
    logic             valid_reg;
    logic [OUT_W-1:0] data_reg, data_next;

    logic [COL_W:0]   col_wide;
    logic [ROW_W:0]   row_wide;
    logic [ROW_W:0]   phys_sum;
    logic [ROW_W-1:0] phys_row;
    logic             we, ce;
    logic [15:0]      cell_value, fill_value;
    logic [ROW_W-1:0] clear_row;
    logic [POS_W-1:0] position;
    logic             step;

    assign pop_ready = !valid_reg || out_ready;
    assign step      = pop_valid && pop_ready;

    always_comb
    begin
        phys_sum = {1'b0, top_reg} + {1'b0, row_reg};
        if (phys_sum >= (ROW_W + 1)'(ROWS))
            phys_sum = phys_sum - (ROW_W + 1)'(ROWS);
        phys_row = phys_sum[ROW_W-1:0];

        we       = 1'b0;
        col_wide = {1'b0, col_reg};
        row_wide = {1'b0, row_reg};
        unique case (pop_cmd.op)
            OP_WRITE:
            begin
                we       = 1'b1;
                col_wide = {1'b0, col_reg} + (COL_W + 1)'(1);
            end
            OP_NEWLINE:
            begin
                col_wide = '0;
                row_wide = {1'b0, row_reg} + (ROW_W + 1)'(1);
            end
            OP_RETURN:
                col_wide = '0;
            OP_BACKSPACE:
            begin
                if (col_reg != '0)
                    col_wide = {1'b0, col_reg} - (COL_W + 1)'(1);
            end
            default:
                ;
        endcase

        // wrap at the end of a row
        if (col_wide >= (COL_W + 1)'(COLS))
        begin
            col_wide = '0;
            row_wide = row_wide + (ROW_W + 1)'(1);
        end

        ce       = 1'b0;
        top_next = top_reg;
        if (row_wide >= (ROW_W + 1)'(ROWS))
        begin
            ce       = 1'b1;
            row_wide = (ROW_W + 1)'(ROWS - 1);
            top_next = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + ROW_W'(1);
        end
        col_next = col_wide[COL_W-1:0];
        row_next = row_wide[ROW_W-1:0];

        cell_value = we ? {pop_cmd.attr, pop_cmd.ch} : 16'h0000;
        fill_value = ce ? {pop_cmd.attr, CHAR_BLANK} : 16'h0000;
        clear_row  = ce ? top_reg : '0;
        position   = POS_W'(row_next) * POS_W'(COLS) + POS_W'(col_next);

        data_next = {5'b0, position, top_next, fill_value, clear_row, ce,
                     cell_value, we ? col_reg : COL_W'(0),
                     we ? phys_row : ROW_W'(0), we};
    end

    always_ff @(posedge clk)
    begin
        if (step)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            top_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                top_reg <= top_next;
            end
            if (step)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < COL_W'(COLS)) && (row_reg < ROW_W'(ROWS)))
        else $error("cursor outside the screen");
    assert property (@(posedge clk) disable iff (!rst_n) top_reg < ROW_W'(ROWS))
        else $error("top offset outside the ring");
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && ce) |=> (row_reg == ROW_W'(ROWS - 1)))
        else $error("scroll did not park the cursor on the last row");
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (top_reg == out_data[55:51]))
        else $error("reported top row differs from the ring offset");

endmodule

`default_nettype wire
